>>> design/vcg_pkg.sv
package vcg_pkg;

  localparam int unsigned GUARD_ROWS  = 1024;
  localparam int unsigned ARMED_SLOTS = 1024;

  localparam int unsigned ROW_AW = $clog2(GUARD_ROWS);
  localparam int unsigned ROW_CW = $clog2(GUARD_ROWS + 1);
  localparam int unsigned ARM_AW = $clog2(ARMED_SLOTS);
  localparam int unsigned CFG_W  = 11;

  localparam logic [63:0] MUL_A = 64'hFF51AFD7ED558CCD;
  localparam logic [63:0] MUL_B = 64'hC4CEB9FE1A85EC53;

  localparam int unsigned SH_PRE  = 33;
  localparam int unsigned SH_MID  = 29;
  localparam int unsigned SH_POST = 32;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ARM    = 2'd1,
    CMD_DISARM = 2'd2,
    CMD_VERIFY = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    VD_DONE      = 3'd0,
    VD_PASS_HIT  = 3'd1,
    VD_PASS_FREE = 3'd2,
    VD_TRAP_MISS = 3'd3,
    VD_TRAP_ARM  = 3'd4
  } verdict_e;

  typedef enum logic [7:0] {
    ST_CLR    = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_HASH   = 8'b0000_0100,
    ST_ARMWR  = 8'b0000_1000,
    ST_DISRD  = 8'b0001_0000,
    ST_DISCHK = 8'b0010_0000,
    ST_SCAN   = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_e;

endpackage

>>> design/vcg_ram.sv
module vcg_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> design/virtual_call_target_guard_unit.sv
// Virtual-call target guard. Load (0), arm (1), disarm (2) and verify (3)
// commands each return one verdict. After reset the armed-address table is
// cleared one entry a cycle (ARMED_SLOTS entries, 1024) while in_stall_o is
// high. Arm and disarm first hash the storage address on one shared 32x32
// multiplier, 3 partial products per 64-bit multiply. A verify also takes
// the hash, then reads guard rows from the row memory one per cycle until
// the first row whose table pointer and slot match, up to min(entry_count,
// GUARD_ROWS) rows. A finished verdict sits in an output register, so the
// next command is taken while it waits.
module virtual_call_target_guard_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             cmd_i,
  input  logic [9:0]             entry_index_i,
  input  logic [63:0]            storage_addr_i,
  input  logic [63:0]            table_ptr_i,
  input  logic [63:0]            slot_offset_i,
  input  logic [63:0]            target_ptr_i,
  input  logic [63:0]            row_cookie_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [2:0]             verdict_o,
  output logic                   trap_o,
  input  logic                   cfg_we_i,
  input  logic [10:0]            cfg_wdata_i
);
  import vcg_pkg::*;

  state_e state_q, state_d;
  logic   armchk_q, armchk_d;

  logic [CFG_W-1:0]  entry_count_q;
  logic [ROW_CW-1:0] n_sat;
  logic [ROW_CW-1:0] n_q, n_d;
  logic [ROW_CW-1:0] issue_q, issue_d;
  logic              pend_q, pend_d;

  logic [ARM_AW-1:0] clr_q, clr_d;
  logic [ARM_AW-1:0] idx_q, idx_d;

  cmd_e        cmd_q, cmd_d;
  logic [63:0] addr_q, addr_d;
  logic [63:0] tp_q, tp_d;
  logic [63:0] slot_q, slot_d;
  logic [63:0] tgt_q, tgt_d;

  logic [63:0] x_q, x_d;
  logic [63:0] acc_q, acc_d;
  logic [1:0]  pp_q, pp_d;
  logic        msel_q, msel_d;
  logic [31:0] op_a, op_b;
  logic [63:0] mul_p;
  logic [63:0] kmul;
  logic [63:0] xfin;

  verdict_e vd_q, vd_d;
  logic     out_valid_q, out_valid_d;
  verdict_e out_vd_q, out_vd_d;

  logic              g_we;
  logic [ROW_AW-1:0] g_waddr, g_raddr;
  logic [191:0]      g_wdata, g_rdata;
  logic              a_we;
  logic [ARM_AW-1:0] a_waddr;
  logic [63:0]       a_wdata, a_rdata;

  logic in_xfer, out_free, row_hit;

  vcg_ram #(.Width(192), .Depth(GUARD_ROWS)) u_guard_ram (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (g_wdata),
    .raddr_i (g_raddr),
    .rdata_o (g_rdata)
  );

  vcg_ram #(.Width(64), .Depth(ARMED_SLOTS)) u_armed_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (a_wdata),
    .raddr_i (idx_q),
    .rdata_o (a_rdata)
  );

  assign in_stall_o  = (state_q != ST_IDLE) || armchk_q;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign verdict_o   = out_vd_q;
  assign trap_o      = (out_vd_q == VD_TRAP_MISS) || (out_vd_q == VD_TRAP_ARM);

  assign n_sat = (entry_count_q > CFG_W'(GUARD_ROWS)) ? ROW_CW'(GUARD_ROWS)
                                                      : ROW_CW'(entry_count_q);

  // 64x64 low product as three 32x32 partial products
  assign kmul = msel_q ? MUL_B : MUL_A;
  always_comb begin
    case (pp_q)
      2'd0: begin
        op_a = x_q[31:0];
        op_b = kmul[31:0];
      end
      2'd1: begin
        op_a = x_q[31:0];
        op_b = kmul[63:32];
      end
      default: begin
        op_a = x_q[63:32];
        op_b = kmul[31:0];
      end
    endcase
  end
  assign mul_p = op_a * op_b;
  assign acc_d = (pp_q == 2'd0) ? mul_p
                                : {acc_q[63:32] + mul_p[31:0], acc_q[31:0]};
  assign xfin  = msel_q ? (acc_d ^ (acc_d >> SH_POST)) : (acc_d ^ (acc_d >> SH_MID));

  assign g_raddr = issue_q[ROW_AW-1:0];
  assign row_hit = pend_q && (g_rdata[63:0] == tp_q) && (g_rdata[127:64] == slot_q);
  assign g_we    = in_xfer && (cmd_e'(cmd_i) == CMD_LOAD)
                   && ({1'b0, entry_index_i} < 11'(GUARD_ROWS));
  assign g_waddr = entry_index_i[ROW_AW-1:0];
  assign g_wdata = {target_ptr_i, slot_offset_i, table_ptr_i};

  always_comb begin
    state_d     = state_q;
    armchk_d    = armchk_q;
    clr_d       = clr_q;
    idx_d       = idx_q;
    cmd_d       = cmd_q;
    addr_d      = addr_q;
    tp_d        = tp_q;
    slot_d      = slot_q;
    tgt_d       = tgt_q;
    x_d         = x_q;
    pp_d        = pp_q;
    msel_d      = msel_q;
    n_d         = n_q;
    issue_d     = issue_q;
    pend_d      = 1'b0;
    vd_d        = vd_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_vd_d    = out_vd_q;
    a_we        = 1'b0;
    a_waddr     = idx_q;
    a_wdata     = addr_q;

    if (armchk_q) begin
      vd_d     = (a_rdata == addr_q) ? VD_TRAP_ARM : VD_PASS_FREE;
      armchk_d = 1'b0;
      state_d  = ST_DONE;
    end else begin
      case (state_q)
        ST_CLR: begin
          a_we    = 1'b1;
          a_waddr = clr_q;
          a_wdata = '0;
          clr_d   = clr_q + 1'b1;
          if (clr_q == ARM_AW'(ARMED_SLOTS - 1)) begin
            state_d = ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_xfer) begin
            cmd_d  = cmd_e'(cmd_i);
            addr_d = storage_addr_i;
            tp_d   = table_ptr_i;
            slot_d = slot_offset_i;
            tgt_d  = target_ptr_i;
            x_d    = storage_addr_i ^ (storage_addr_i >> SH_PRE);
            pp_d   = 2'd0;
            msel_d = 1'b0;
            vd_d   = VD_DONE;
            state_d = (cmd_e'(cmd_i) == CMD_LOAD) ? ST_DONE : ST_HASH;
          end
        end
        ST_HASH: begin
          if (pp_q == 2'd2) begin
            pp_d = 2'd0;
            if (!msel_q) begin
              x_d    = xfin;
              msel_d = 1'b1;
            end else begin
              idx_d = xfin[ARM_AW-1:0];
              case (cmd_q)
                CMD_ARM:    state_d = ST_ARMWR;
                CMD_DISARM: state_d = ST_DISRD;
                default: begin
                  state_d = ST_SCAN;
                  n_d     = n_sat;
                  issue_d = '0;
                end
              endcase
            end
          end else begin
            pp_d = pp_q + 2'd1;
          end
        end
        ST_ARMWR: begin
          a_we    = 1'b1;
          state_d = ST_DONE;
        end
        ST_DISRD: begin
          state_d = ST_DISCHK;
        end
        ST_DISCHK: begin
          a_we    = (a_rdata == addr_q);
          a_wdata = '0;
          state_d = ST_DONE;
        end
        ST_SCAN: begin
          if (row_hit) begin
            vd_d    = (g_rdata[191:128] == tgt_q) ? VD_PASS_HIT : VD_TRAP_MISS;
            state_d = ST_DONE;
          end else if (issue_q < n_q) begin
            issue_d = issue_q + 1'b1;
            pend_d  = 1'b1;
          end else begin
            armchk_d = 1'b1;
            state_d  = ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_vd_d    = vd_q;
            state_d     = ST_IDLE;
          end
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLR;
      armchk_q      <= 1'b0;
      clr_q         <= '0;
      pend_q        <= 1'b0;
      out_valid_q   <= 1'b0;
      entry_count_q <= '0;
    end else begin
      state_q     <= state_d;
      armchk_q    <= armchk_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        entry_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    cmd_q    <= cmd_d;
    addr_q   <= addr_d;
    tp_q     <= tp_d;
    slot_q   <= slot_d;
    tgt_q    <= tgt_d;
    x_q      <= x_d;
    acc_q    <= acc_d;
    pp_q     <= pp_d;
    msel_q   <= msel_d;
    n_q      <= n_d;
    issue_q  <= issue_d;
    vd_q     <= vd_d;
    out_vd_q <= out_vd_d;
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import vcg_pkg::*;

  localparam logic [63:0] GOLD = 64'h9E3779B97F4A7C15;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  cmd_i = CMD_LOAD;
  logic [9:0]  entry_index_i = '0;
  logic [63:0] storage_addr_i = '0;
  logic [63:0] table_ptr_i = '0;
  logic [63:0] slot_offset_i = '0;
  logic [63:0] target_ptr_i = '0;
  logic [63:0] row_cookie_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  verdict_o;
  logic        trap_o;
  logic        cfg_we_i = 1'b0;
  logic [10:0] cfg_wdata_i = '0;

  typedef struct packed {
    verdict_e verdict;
    logic     trap;
  } verdict_t;

  verdict_t    verdict_q[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  logic [63:0] row_tp[GUARD_ROWS];
  logic [63:0] row_slot[GUARD_ROWS];
  logic [63:0] row_tgt[GUARD_ROWS];
  logic [63:0] row_cookie[GUARD_ROWS];
  logic [63:0] armed[ARMED_SLOTS];
  logic [10:0] scan_count = '0;
  logic [63:0] addr_pool[8];

  virtual_call_target_guard_unit DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i, .entry_index_i,
    .storage_addr_i, .table_ptr_i, .slot_offset_i, .target_ptr_i, .row_cookie_i,
    .out_valid_o, .out_stall_i, .verdict_o, .trap_o, .cfg_we_i, .cfg_wdata_i
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #100_000_000;
    $display("tb: errors");
    $finish;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] fmix(logic [63:0] x);
    x = (x ^ (x >> 33)) * MUL_A;
    x = (x ^ (x >> 33)) * MUL_B;
    return x ^ (x >> 33);
  endfunction

  function automatic logic [63:0] call_digest(logic [63:0] tp, logic [63:0] slot,
                                              logic [63:0] tgt, logic [63:0] ck);
    logic [63:0] x;
    x = tp ^ {tgt[46:0], tgt[63:47]};
    x = x ^ (slot * GOLD);
    x = x ^ ck;
    return fmix(x);
  endfunction

  function automatic int armed_slot(logic [63:0] addr);
    logic [63:0] x;
    x = addr;
    x = x ^ (x >> SH_PRE);
    x = x * MUL_A;
    x = x ^ (x >> SH_MID);
    x = x * MUL_B;
    x = x ^ (x >> SH_POST);
    return int'(x[ARM_AW-1:0]);
  endfunction

  function automatic verdict_e guard_verdict(cmd_e cmd, int row, logic [63:0] addr,
                                             logic [63:0] tp, logic [63:0] slot,
                                             logic [63:0] tgt, logic [63:0] ck);
    int n;
    int k;
    k = armed_slot(addr);
    case (cmd)
      CMD_LOAD: begin
        row_tp[row] = tp;
        row_slot[row] = slot;
        row_tgt[row] = tgt;
        row_cookie[row] = ck;
      end
      CMD_ARM: armed[k] = addr;
      CMD_DISARM: if (armed[k] == addr) armed[k] = '0;
      default: begin
        n = (scan_count > GUARD_ROWS) ? GUARD_ROWS : int'(scan_count);
        for (int i = 0; i < n; i++) begin
          if (row_tp[i] == tp && row_slot[i] == slot) begin
            if (call_digest(tp, slot, tgt, row_cookie[i]) ==
                call_digest(row_tp[i], row_slot[i], row_tgt[i], row_cookie[i]))
              return VD_PASS_HIT;
            return VD_TRAP_MISS;
          end
        end
        return (armed[k] == addr) ? VD_TRAP_ARM : VD_PASS_FREE;
      end
    endcase
    return VD_DONE;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transfer: verdict %0d trap %0b",
                                   verdict_o, trap_o);
      end else begin
        verdict_t want;
        want = verdict_q.pop_front();
        if (verdict_o !== want.verdict || trap_o !== want.trap) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: verdict exp %0d got %0d, trap exp %0b got %0b",
                     want.verdict, verdict_o, want.trap, trap_o);
        end
      end
    end
  end

  task automatic send_cmd(cmd_e cmd, logic [9:0] row, logic [63:0] addr,
                          logic [63:0] tp, logic [63:0] slot, logic [63:0] tgt,
                          logic [63:0] ck);
    verdict_t v;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    cmd_i = cmd;
    entry_index_i = row;
    storage_addr_i = addr;
    table_ptr_i = tp;
    slot_offset_i = slot;
    target_ptr_i = tgt;
    row_cookie_i = ck;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    v.verdict = guard_verdict(cmd, int'(row), addr, tp, slot, tgt, ck);
    v.trap = (v.verdict == VD_TRAP_MISS || v.verdict == VD_TRAP_ARM);
    verdict_q = {verdict_q, v};
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_count(logic [10:0] n);
    drain();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = n;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    scan_count = n;
  endtask

  task automatic load_row(int r, logic [63:0] tp, logic [63:0] slot, logic [63:0] tgt,
                          logic [63:0] ck);
    send_cmd(CMD_LOAD, r[9:0], rand64(), tp, slot, tgt, ck);
  endtask

  task automatic verify(logic [63:0] addr, logic [63:0] tp, logic [63:0] slot,
                        logic [63:0] tgt);
    send_cmd(CMD_VERIFY, 10'($urandom), addr, tp, slot, tgt, rand64());
  endtask

  task automatic test_empty_scan();
    write_count(11'd0);
    verify(64'd0, rand64(), rand64(), rand64());
    verify(addr_pool[2], rand64(), rand64(), rand64());
    send_cmd(CMD_ARM, 10'h3FF, addr_pool[2], '1, '1, '1, '1);
    verify(addr_pool[2], rand64(), rand64(), rand64());
    send_cmd(CMD_DISARM, '0, addr_pool[3], '0, '0, '0, '0);
    verify(addr_pool[2], rand64(), rand64(), rand64());
    send_cmd(CMD_DISARM, '0, addr_pool[2], '0, '0, '0, '0);
    verify(addr_pool[2], rand64(), rand64(), rand64());
  endtask

  task automatic test_guard_rows();
    load_row(0, '0, '0, '0, '0);
    load_row(1, '1, '1, '1, '1);
    for (int r = 2; r < 16; r++) load_row(r, rand64(), rand64(), rand64(), rand64());
    load_row(3, row_tp[2], rand64(), rand64(), rand64());
    write_count(11'd16);
    verify('1, '0, '0, '0);
    verify('0, '1, '1, '1);
    verify('0, '1, '1, 64'h7FFF_FFFF_FFFF_FFFF);
    verify(addr_pool[1], row_tp[5], row_slot[5], row_tgt[5]);
    verify(addr_pool[1], row_tp[3], row_slot[3], ~row_tgt[3]);
    verify(addr_pool[1], row_tp[5], ~row_slot[5], row_tgt[5]);
  endtask

  task automatic random_traffic(int sp, int rp, int items);
    int          c;
    int          r;
    logic [63:0] a;
    send_idle_pct = sp;
    recv_idle_pct = rp;
    for (int chunk = 0; chunk < 4; chunk++) begin
      write_count(11'($urandom_range(16)));
      for (int i = 0; i < items / 4; i++) begin
        c = $urandom_range(99);
        a = ($urandom_range(3) == 0) ? rand64() : addr_pool[$urandom_range(7)];
        if (c < 15) begin
          r = ($urandom_range(3) == 0) ? $urandom_range(GUARD_ROWS - 1)
                                       : $urandom_range(15);
          load_row(r, rand64(), rand64(), rand64(), rand64());
        end else if (c < 35) begin
          send_cmd(CMD_ARM, 10'($urandom), a, rand64(), rand64(), rand64(), rand64());
        end else if (c < 50) begin
          send_cmd(CMD_DISARM, 10'($urandom), a, rand64(), rand64(), rand64(), rand64());
        end else if (c < 80 && scan_count != 0) begin
          r = $urandom_range(int'(scan_count) - 1);
          verify(a, row_tp[r], row_slot[r],
                 ($urandom_range(1) == 0) ? row_tgt[r]
                                          : row_tgt[r] ^ (64'd1 << $urandom_range(63)));
        end else begin
          verify(a, rand64(), rand64(), rand64());
        end
      end
    end
  endtask

  task automatic test_full_table();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_count(11'd2047);
    verify(addr_pool[4], row_tp[7], row_slot[7], row_tgt[7]);
    verify(addr_pool[4], row_tp[15], row_slot[15], ~row_tgt[15]);
    write_count(11'd1024);
    verify(addr_pool[5], row_tp[0], row_slot[0], row_tgt[0]);
  endtask

  initial begin
    for (int i = 0; i < ARMED_SLOTS; i++) armed[i] = '0;
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 2; i < 8; i++) addr_pool[i] = rand64();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_empty_scan();
    test_guard_rows();
    random_traffic(33, 62, 180);
    random_traffic(62, 33, 180);
    random_traffic(0, 0, 180);
    test_full_table();
    drain();
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
